@@ rtl/core/size_class_block_allocator_macros.svh @@
// Assertion macros shared by the size class block allocator RTL.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge out of reset.
`define SCBA_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("scba assertion failed");

// Implication checked in the same cycle.
`define SCBA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scba assertion failed");

// Implication checked in the following cycle.
`define SCBA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scba assertion failed");

`else

`define SCBA_ASSERT(lbl, cond)
`define SCBA_ASSERT_IMP(lbl, ante, cons)
`define SCBA_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ rtl/core/scba_pkg.sv @@
// Shared constants, types and helper functions of the size class block allocator.
package scba_pkg;

  // Pool geometry.
  localparam int unsigned SLOTS_PER_CLASS = 4096;
  localparam int unsigned CLASS_COUNT     = 4;
  localparam int unsigned REG_COUNT       = 4;

  // Field widths.
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned SLOT_W    = 12;
  localparam int unsigned CLS_OUT_W = 2;
  localparam int unsigned LIMIT_MAX = 65535;
  localparam int unsigned LIMIT_BASE = 32;

  // Derived widths.
  localparam int unsigned IDX_W     = $clog2(SLOTS_PER_CLASS);
  localparam int unsigned CNT_W     = $clog2(SLOTS_PER_CLASS + 1);
  localparam int unsigned CLS_W     = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int unsigned MEM_DEPTH = CLASS_COUNT * SLOTS_PER_CLASS;
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);
  localparam int unsigned PADDR_W   = $clog2(REG_COUNT * 4);
  localparam int unsigned REG_IDX_W = PADDR_W - 2;
  localparam int unsigned PDATA_W   = 32;

  typedef logic [SIZE_W-1:0]  bytes_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [CLS_W-1:0]   cls_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FALLBACK = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  // Result of the class lookup.
  typedef struct packed {
    logic hit;
    cls_t cls;
  } class_pick_t;

  // Reset limit of a class: 32 shifted left by the class index, saturated.
  function automatic bytes_t limit_reset(int unsigned k);
    logic [31:0] lim;
    lim = (k < 12) ? (32'(LIMIT_BASE) << k) : 32'(LIMIT_MAX);
    if (lim > 32'(LIMIT_MAX)) begin
      lim = 32'(LIMIT_MAX);
    end
    return lim[SIZE_W-1:0];
  endfunction

  // Reset content of a stack entry: its own index, kept to the slot width.
  function automatic slot_t init_slot(idx_t idx);
    logic [IDX_W+SLOT_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, idx};
    return wide[SLOT_W-1:0];
  endfunction

  // Class index as reported on the result port.
  function automatic logic [CLS_OUT_W-1:0] class_code(cls_t c);
    logic [CLS_W+CLS_OUT_W-1:0] wide;
    wide = {{CLS_OUT_W{1'b0}}, c};
    return wide[CLS_OUT_W-1:0];
  endfunction

  // Memory address of one stack entry of one class.
  function automatic addr_t slot_addr(cls_t c, idx_t i);
    return addr_t'(c) * addr_t'(SLOTS_PER_CLASS) + addr_t'(i);
  endfunction

endpackage

@@ rtl/core/size_class_block_allocator.sv @@
// Top level of the size class block allocator: APB limit registers, class lookup, stacks.
// Latency: the result beat is on the result ports in the cycle after start is taken.
// Throughput: one request per cycle; each request makes at most one access to the stack RAM.
// Reset: limits return to 32, 64, 128 and 256 and every class stack is full; no clearing pass.
// The result strobe lasts one cycle and the receiver cannot stall it.
module size_class_block_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            action_i,
  input  logic [scba_pkg::SIZE_W-1:0]     request_bytes_i,
  input  logic [scba_pkg::SLOT_W-1:0]     freed_slot_i,
  output logic                            done_o,
  output logic [1:0]                      status_o,
  output logic [scba_pkg::CLS_OUT_W-1:0]  size_class_o,
  output logic [scba_pkg::SLOT_W-1:0]     granted_slot_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [scba_pkg::PADDR_W-1:0]    paddr,
  input  logic [scba_pkg::PDATA_W-1:0]    pwdata,
  output logic [scba_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  scba_pkg::bytes_t               limit_q [scba_pkg::CLASS_COUNT];
  logic [scba_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           cfg_we;
  logic                           accept;
  scba_pkg::class_pick_t          pick;

  // The stacks take a request every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Register interface.
  assign pready  = 1'b1;
  assign reg_idx = paddr[scba_pkg::PADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  // Class limit registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < scba_pkg::CLASS_COUNT; k++) begin
        limit_q[k] <= scba_pkg::limit_reset(k);
      end
    end else begin
      for (int k = 0; k < scba_pkg::CLASS_COUNT; k++) begin
        if (cfg_we && (k < scba_pkg::REG_COUNT) &&
            (reg_idx == scba_pkg::REG_IDX_W'(k))) begin
          limit_q[k] <= pwdata[scba_pkg::SIZE_W-1:0];
        end
      end
    end
  end

  // Read back of the limit registers.
  always_comb begin
    prdata = '0;
    for (int k = 0; k < scba_pkg::CLASS_COUNT; k++) begin
      if ((k < scba_pkg::REG_COUNT) && (reg_idx == scba_pkg::REG_IDX_W'(k))) begin
        prdata = scba_pkg::PDATA_W'(limit_q[k]);
      end
    end
  end

  // Class lookup.
  scba_class_sel u_class_sel (
    .request_bytes_i (request_bytes_i),
    .limit_i         (limit_q),
    .pick_o          (pick)
  );

  // Free slot stacks and result stage.
  scba_stack_ctrl u_stack_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .action_i       (action_i),
    .pick_i         (pick),
    .freed_slot_i   (freed_slot_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .size_class_o   (size_class_o),
    .granted_slot_o (granted_slot_o)
  );

endmodule

@@ rtl/core/scba_ram.sv @@
// Generic single-port RAM with registered read data.
module scba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One access per cycle; read data appears in the following cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/scba_class_sel.sv @@
// Maps a request size to the first class whose limit holds it.
module scba_class_sel (
  input  scba_pkg::bytes_t      request_bytes_i,
  input  scba_pkg::bytes_t      limit_i [scba_pkg::CLASS_COUNT],
  output scba_pkg::class_pick_t pick_o
);

  // Scan from the top down so that the lowest matching class wins.
  always_comb begin
    pick_o.hit = 1'b0;
    pick_o.cls = '0;
    for (int k = scba_pkg::CLASS_COUNT - 1; k >= 0; k--) begin
      if (request_bytes_i <= limit_i[k]) begin
        pick_o.hit = 1'b1;
        pick_o.cls = scba_pkg::cls_t'(k);
      end
    end
  end

endmodule

@@ rtl/core/scba_stack_ctrl.sv @@
// Free slot stacks: per-class counts, low water marks, stack memory and result stage.
`include "size_class_block_allocator_macros.svh"

module scba_stack_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       action_i,
  input  scba_pkg::class_pick_t      pick_i,
  input  scba_pkg::slot_t            freed_slot_i,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [scba_pkg::CLS_OUT_W-1:0] size_class_o,
  output scba_pkg::slot_t            granted_slot_o
);

  scba_pkg::cnt_t    count_q [scba_pkg::CLASS_COUNT];
  scba_pkg::cnt_t    count_d [scba_pkg::CLASS_COUNT];
  scba_pkg::cnt_t    low_q   [scba_pkg::CLASS_COUNT];
  scba_pkg::cnt_t    low_d   [scba_pkg::CLASS_COUNT];
  scba_pkg::cnt_t    cnt_sel;
  scba_pkg::cnt_t    cnt_dec;
  scba_pkg::cnt_t    low_sel;
  scba_pkg::idx_t    mem_idx;
  scba_pkg::addr_t   mem_addr;
  scba_pkg::status_e status_d;
  scba_pkg::slot_t   ram_rdata;
  logic              is_free;
  logic              pool_empty;
  logic              stack_full;
  logic              pop_en;
  logic              push_en;
  logic              from_init;

  logic              res_valid_q;
  scba_pkg::status_e res_status_q;
  scba_pkg::cls_t    res_cls_q;
  logic              res_pop_q;
  logic              res_init_q;
  scba_pkg::slot_t   res_init_slot_q;

  // Decide the outcome and the stack access of the accepted beat.
  // An entry below the lowest count ever reached was never written since
  // reset, so it still holds its reset value and is served without the memory.
  always_comb begin
    cnt_sel    = count_q[pick_i.cls];
    low_sel    = low_q[pick_i.cls];
    cnt_dec    = cnt_sel - scba_pkg::cnt_t'(1);
    is_free    = (action_i == scba_pkg::ACT_FREE);
    pool_empty = (cnt_sel == '0);
    stack_full = (cnt_sel == scba_pkg::cnt_t'(scba_pkg::SLOTS_PER_CLASS));
    from_init  = (cnt_dec < low_sel);

    if (!pick_i.hit) begin
      status_d = scba_pkg::ST_FALLBACK;
    end else if (is_free) begin
      status_d = stack_full ? scba_pkg::ST_FULL : scba_pkg::ST_OK;
    end else begin
      status_d = pool_empty ? scba_pkg::ST_EMPTY : scba_pkg::ST_OK;
    end

    pop_en  = accept_i && pick_i.hit && !is_free && !pool_empty;
    push_en = accept_i && pick_i.hit && is_free && !stack_full;
    mem_idx = push_en ? cnt_sel[scba_pkg::IDX_W-1:0] : cnt_dec[scba_pkg::IDX_W-1:0];
    mem_addr = scba_pkg::slot_addr(pick_i.cls, mem_idx);

    count_d = count_q;
    low_d   = low_q;
    if (pop_en) begin
      count_d[pick_i.cls] = cnt_dec;
      if (from_init) begin
        low_d[pick_i.cls] = cnt_dec;
      end
    end
    if (push_en) begin
      count_d[pick_i.cls] = cnt_sel + scba_pkg::cnt_t'(1);
    end
  end

  // Counts and low water marks start at a full stack.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < scba_pkg::CLASS_COUNT; k++) begin
        count_q[k] <= scba_pkg::cnt_t'(scba_pkg::SLOTS_PER_CLASS);
        low_q[k]   <= scba_pkg::cnt_t'(scba_pkg::SLOTS_PER_CLASS);
      end
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      low_q       <= low_d;
      res_valid_q <= accept_i;
    end
  end

  // Result payload, shown with the read data in the next cycle.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      res_status_q    <= status_d;
      res_cls_q       <= pick_i.cls;
      res_pop_q       <= pop_en;
      res_init_q      <= from_init;
      res_init_slot_q <= scba_pkg::init_slot(cnt_dec[scba_pkg::IDX_W-1:0]);
    end
  end

  // Stack memory of all classes.
  scba_ram #(
    .WIDTH (scba_pkg::SLOT_W),
    .DEPTH (scba_pkg::MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push_en),
    .re_i    (pop_en),
    .addr_i  (mem_addr),
    .wdata_i (freed_slot_i),
    .rdata_o (ram_rdata)
  );

  // Result beat.
  assign done_o         = res_valid_q;
  assign status_o       = res_status_q;
  assign size_class_o   = scba_pkg::class_code(res_cls_q);
  assign granted_slot_o = res_pop_q ? (res_init_q ? res_init_slot_q : ram_rdata) : '0;

  // Checks.
  `SCBA_ASSERT_NXT(a_result_follows, accept_i, res_valid_q)
  `SCBA_ASSERT_IMP(a_fallback_no_access, accept_i && !pick_i.hit, !push_en && !pop_en)
  `SCBA_ASSERT_NXT(a_push_grows, push_en, count_q[res_cls_q] == $past(cnt_sel) + scba_pkg::cnt_t'(1))
  `SCBA_ASSERT_NXT(a_pop_shrinks, pop_en, count_q[res_cls_q] == $past(cnt_dec))

  for (genvar k = 0; k < scba_pkg::CLASS_COUNT; k++) begin : g_low_chk
    `SCBA_ASSERT(a_low_le_count, low_q[k] <= count_q[k])
  end

endmodule
